// ===== sv/twot_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and constants for the overcurrent trip core
package twot_pkg;

   // fixed field widths
   localparam int CURRENT_BITS   = 16;
   localparam int DT_BITS        = 16;
   localparam int THRESH_BITS    = 16;
   localparam int WINDOW_REG_BITS = 24;
   localparam int LEVEL_BITS     = 24;
   localparam int FAULT_BITS     = 8;
   localparam int STATE_BITS     = 2;
   localparam int CAUSE_BITS     = 2;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;

   // defaults
   localparam int WINDOW_BITS_DEF = 24;
   localparam logic [DT_BITS-1:0] DT_CAP_MS = 16'd1000;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_PROTECT_ENABLE  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LONG_THRESHOLD  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SHORT_THRESHOLD = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LONG_WINDOW     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SHORT_WINDOW    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LATCH_AFTER     = 3'd5;

   // register reset values
   localparam logic                       PROTECT_ENABLE_RST  = 1'b1;
   localparam logic [THRESH_BITS-1:0]     LONG_THRESHOLD_RST  = 16'd8000;
   localparam logic [THRESH_BITS-1:0]     SHORT_THRESHOLD_RST = 16'd10000;
   localparam logic [WINDOW_REG_BITS-1:0] LONG_WINDOW_RST     = 24'd180000;
   localparam logic [WINDOW_REG_BITS-1:0] SHORT_WINDOW_RST    = 24'd60000;
   localparam logic [FAULT_BITS-1:0]      LATCH_AFTER_RST     = 8'd5;

   localparam logic [FAULT_BITS-1:0] FAULT_MAX = {FAULT_BITS{1'b1}};

   // trip cause codes
   localparam logic [CAUSE_BITS-1:0] CAUSE_NONE  = 2'd0;
   localparam logic [CAUSE_BITS-1:0] CAUSE_SHORT = 2'd1;
   localparam logic [CAUSE_BITS-1:0] CAUSE_LONG  = 2'd2;

   // rail state codes as seen on the result channel
   localparam logic [STATE_BITS-1:0] STATE_READY   = 2'd0;
   localparam logic [STATE_BITS-1:0] STATE_RUNNING = 2'd1;
   localparam logic [STATE_BITS-1:0] STATE_TRIPPED = 2'd2;
   localparam logic [STATE_BITS-1:0] STATE_LATCHED = 2'd3;

   typedef enum logic [1:0] {
      REQ_SAMPLE  = 2'd0,
      REQ_ENABLE  = 2'd1,
      REQ_DISABLE = 2'd2,
      REQ_CLEAR   = 2'd3
   } req_code_type;

   typedef enum logic [3:0] {
      MODE_READY   = 4'b0001,
      MODE_RUNNING = 4'b0010,
      MODE_TRIPPED = 4'b0100,
      MODE_LATCHED = 4'b1000
   } mode_type;

   typedef struct packed {
      logic                       protect_enable;
      logic [THRESH_BITS-1:0]     long_threshold;
      logic [THRESH_BITS-1:0]     short_threshold;
      logic [WINDOW_REG_BITS-1:0] long_window;
      logic [WINDOW_REG_BITS-1:0] short_window;
      logic [FAULT_BITS-1:0]      latch_after;
   } cfg_type;

   typedef struct packed {
      mode_type                mode;
      logic [FAULT_BITS-1:0]   faults;
      logic [CAUSE_BITS-1:0]   cause;
      logic                    refused;
      logic                    take_bucket;
      logic                    clear_accum;
   } decision_type;

   function automatic logic [STATE_BITS-1:0] mode_code(input mode_type mode);
      logic [STATE_BITS-1:0] code;
      unique case (mode)
         MODE_READY:   code = STATE_READY;
         MODE_RUNNING: code = STATE_RUNNING;
         MODE_TRIPPED: code = STATE_TRIPPED;
         MODE_LATCHED: code = STATE_LATCHED;
         default:      code = STATE_READY;
      endcase
      return code;
   endfunction

endpackage

// ===== sv/twot_csr.sv =====
`timescale 1ns / 1ps
// configuration register file of the overcurrent trip core
module twot_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [twot_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [twot_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output twot_pkg::cfg_type                     cfg
);
   import twot_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_PROTECT_ENABLE:  cfg_in.protect_enable  = csr_wdata[0];
            REG_LONG_THRESHOLD:  cfg_in.long_threshold  = csr_wdata[THRESH_BITS-1:0];
            REG_SHORT_THRESHOLD: cfg_in.short_threshold = csr_wdata[THRESH_BITS-1:0];
            REG_LONG_WINDOW:     cfg_in.long_window     = csr_wdata[WINDOW_REG_BITS-1:0];
            REG_SHORT_WINDOW:    cfg_in.short_window    = csr_wdata[WINDOW_REG_BITS-1:0];
            REG_LATCH_AFTER:     cfg_in.latch_after     = csr_wdata[FAULT_BITS-1:0];
            default:             cfg_in = cfg_ff;   // unmapped index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.protect_enable  <= PROTECT_ENABLE_RST;
         cfg_ff.long_threshold  <= LONG_THRESHOLD_RST;
         cfg_ff.short_threshold <= SHORT_THRESHOLD_RST;
         cfg_ff.long_window     <= LONG_WINDOW_RST;
         cfg_ff.short_window    <= SHORT_WINDOW_RST;
         cfg_ff.latch_after     <= LATCH_AFTER_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/twot_bucket.sv =====
`timescale 1ns / 1ps
// one leaky-bucket time accumulator step with window cap and full flag
module twot_bucket #(
   parameter int WINDOW_BITS = twot_pkg::WINDOW_BITS_DEF
) (
   input  logic [WINDOW_BITS-1:0]                level,
   input  logic [twot_pkg::DT_BITS-1:0]          dt,
   input  logic                                  over,
   input  logic [twot_pkg::WINDOW_REG_BITS-1:0]  window,
   output logic [WINDOW_BITS-1:0]                level_next,
   output logic                                  full
);
   import twot_pkg::*;

   // one spare bit above the wider of accumulator and window register
   localparam int CALC_BITS =
      ((WINDOW_BITS > WINDOW_REG_BITS) ? WINDOW_BITS : WINDOW_REG_BITS) + 1;

   logic [CALC_BITS-1:0] lvl_x;
   logic [CALC_BITS-1:0] dt_x;
   logic [CALC_BITS-1:0] win_x;
   logic [CALC_BITS-1:0] acc_max;
   logic [CALC_BITS-1:0] cap;
   logic [CALC_BITS-1:0] sum;
   logic [CALC_BITS-1:0] nxt;

   always_comb begin
      lvl_x   = CALC_BITS'(level);
      dt_x    = CALC_BITS'(dt);
      win_x   = CALC_BITS'(window);
      acc_max = CALC_BITS'({WINDOW_BITS{1'b1}});
      cap     = (win_x > acc_max) ? acc_max : win_x;
      sum     = lvl_x + dt_x;
      if (over) begin
         nxt = (sum > cap) ? cap : sum;
      end else begin
         nxt = (lvl_x > dt_x) ? (lvl_x - dt_x) : '0;
      end
      level_next = WINDOW_BITS'(nxt);
      full       = (nxt >= win_x);
   end

endmodule

// ===== sv/twot_mode.sv =====
`timescale 1ns / 1ps
// rail mode, fault counting and command decisions for one item
module twot_mode (
   input  twot_pkg::req_code_type               req_code,
   input  twot_pkg::mode_type                   mode,
   input  logic [twot_pkg::FAULT_BITS-1:0]      faults,
   input  twot_pkg::cfg_type                    cfg,
   input  logic                                 short_full,
   input  logic                                 long_full,
   output twot_pkg::decision_type               dec
);
   import twot_pkg::*;

   logic [FAULT_BITS-1:0] faults_inc;
   mode_type              trip_mode;

   always_comb begin
      faults_inc = (faults == FAULT_MAX) ? FAULT_MAX : (faults + 1'b1);
      trip_mode  = (faults_inc < cfg.latch_after) ? MODE_TRIPPED : MODE_LATCHED;

      dec             = '0;
      dec.mode        = mode;
      dec.faults      = faults;
      dec.cause       = CAUSE_NONE;

      case (req_code)
         REQ_SAMPLE: begin
            if (cfg.protect_enable) begin
               dec.take_bucket = 1'b1;
               if (short_full) begin
                  dec.cause  = CAUSE_SHORT;
                  dec.faults = faults_inc;
                  dec.mode   = trip_mode;
               end else if (long_full) begin
                  dec.cause  = CAUSE_LONG;
                  dec.faults = faults_inc;
                  dec.mode   = trip_mode;
               end
            end
         end
         REQ_ENABLE: begin
            if (mode == MODE_LATCHED) begin
               dec.refused = 1'b1;
            end else begin
               dec.mode        = MODE_RUNNING;
               dec.clear_accum = 1'b1;
            end
         end
         REQ_DISABLE: begin
            if (mode == MODE_RUNNING) begin
               dec.mode = MODE_READY;
            end
         end
         default: begin
            // clear latch, only acts while latched
            if (mode == MODE_LATCHED) begin
               dec.mode        = MODE_READY;
               dec.faults      = '0;
               dec.clear_accum = 1'b1;
            end
         end
      endcase
   end

endmodule

// ===== sv/time_windowed_overcurrent_trip_core.sv =====
`timescale 1ns / 1ps
// top level of the time-windowed overcurrent trip core
//
// Guards one power rail with two leaky-bucket time accumulators, a short and
// a long window. Each req item is a sample (current and elapsed ms, the latter
// clipped at DT_CAP_MS) or an enable, disable or clear-latch command, and gives
// exactly one rsp item with the rail state, the trip cause, the fault count,
// the refused flag and both accumulator levels after the step. The core takes
// one item per clock while req_stall is low: an accepted item sits in the
// input register, the whole update (two add/compare/saturate buckets and the
// mode logic) is combinational on it and lands in the result register with
// the new state once that register is free, raising rsp_valid. The result
// register lets a new item be taken while an earlier result still waits;
// req_stall rises only when the input register is full and the result register
// is held by rsp_stall. Configuration goes through csr_we/csr_index/csr_wdata
// and must only be written while no item is in flight; unmapped indexes are
// ignored.
module time_windowed_overcurrent_trip_core #(
   parameter int WINDOW_BITS = twot_pkg::WINDOW_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_we,
   input  logic [twot_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [twot_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   // request channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [1:0]                            req_type,
   input  logic [twot_pkg::CURRENT_BITS-1:0]     req_current,
   input  logic [twot_pkg::DT_BITS-1:0]          req_elapsed_ms,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [twot_pkg::STATE_BITS-1:0]       rsp_rail_state,
   output logic [twot_pkg::CAUSE_BITS-1:0]       rsp_trip_cause,
   output logic [twot_pkg::FAULT_BITS-1:0]       rsp_faults,
   output logic                                  rsp_refused,
   output logic [twot_pkg::LEVEL_BITS-1:0]       rsp_long_level,
   output logic [twot_pkg::LEVEL_BITS-1:0]       rsp_short_level
);
   import twot_pkg::*;

   cfg_type cfg;

   // input register
   logic                     in_valid_ff;
   logic                     in_valid_in;
   req_code_type             in_code_ff;
   logic [CURRENT_BITS-1:0]  in_current_ff;
   logic [DT_BITS-1:0]       in_elapsed_ff;

   // rail state
   logic [WINDOW_BITS-1:0]   long_accum_ff;
   logic [WINDOW_BITS-1:0]   long_accum_in;
   logic [WINDOW_BITS-1:0]   short_accum_ff;
   logic [WINDOW_BITS-1:0]   short_accum_in;
   logic [FAULT_BITS-1:0]    faults_ff;
   mode_type                 mode_ff;

   // result register
   logic                     out_valid_ff;
   logic                     out_valid_in;
   logic [STATE_BITS-1:0]    out_state_ff;
   logic [CAUSE_BITS-1:0]    out_cause_ff;
   logic [FAULT_BITS-1:0]    out_faults_ff;
   logic                     out_refused_ff;
   logic [LEVEL_BITS-1:0]    out_long_ff;
   logic [LEVEL_BITS-1:0]    out_short_ff;

   // handshake
   logic                     out_free;
   logic                     fire;
   logic                     req_accept;

   // datapath
   logic [DT_BITS-1:0]       dt;
   logic [WINDOW_BITS-1:0]   long_next;
   logic [WINDOW_BITS-1:0]   short_next;
   logic                     long_full;
   logic                     short_full;
   decision_type             dec;

   twot_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // result register can take a new item when empty or being drained
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign fire       = in_valid_ff && out_free;
   assign req_stall  = in_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   // elapsed time clip
   assign dt = (in_elapsed_ff > DT_CAP_MS) ? DT_CAP_MS : in_elapsed_ff;

   twot_bucket #(.WINDOW_BITS(WINDOW_BITS)) u_long (
      .level      (long_accum_ff),
      .dt         (dt),
      .over       (in_current_ff >= cfg.long_threshold),
      .window     (cfg.long_window),
      .level_next (long_next),
      .full       (long_full)
   );

   twot_bucket #(.WINDOW_BITS(WINDOW_BITS)) u_short (
      .level      (short_accum_ff),
      .dt         (dt),
      .over       (in_current_ff >= cfg.short_threshold),
      .window     (cfg.short_window),
      .level_next (short_next),
      .full       (short_full)
   );

   twot_mode u_mode (
      .req_code   (in_code_ff),
      .mode       (mode_ff),
      .faults     (faults_ff),
      .cfg        (cfg),
      .short_full (short_full),
      .long_full  (long_full),
      .dec        (dec)
   );

   // accumulators: cleared by enable/clear latch, stepped by protected samples
   always_comb begin
      long_accum_in  = long_accum_ff;
      short_accum_in = short_accum_ff;
      if (dec.clear_accum) begin
         long_accum_in  = '0;
         short_accum_in = '0;
      end else if (dec.take_bucket) begin
         long_accum_in  = long_next;
         short_accum_in = short_next;
      end
   end

   // control state and rail state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         long_accum_ff  <= '0;
         short_accum_ff <= '0;
         faults_ff      <= '0;
         mode_ff        <= MODE_READY;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            long_accum_ff  <= long_accum_in;
            short_accum_ff <= short_accum_in;
            faults_ff      <= dec.faults;
            mode_ff        <= dec.mode;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_code_ff    <= req_code_type'(req_type);
         in_current_ff <= req_current;
         in_elapsed_ff <= req_elapsed_ms;
      end
      if (fire) begin
         out_state_ff   <= mode_code(dec.mode);
         out_cause_ff   <= dec.cause;
         out_faults_ff  <= dec.faults;
         out_refused_ff <= dec.refused;
         out_long_ff    <= LEVEL_BITS'(long_accum_in);
         out_short_ff   <= LEVEL_BITS'(short_accum_in);
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_rail_state  = out_state_ff;
   assign rsp_trip_cause  = out_cause_ff;
   assign rsp_faults      = out_faults_ff;
   assign rsp_refused     = out_refused_ff;
   assign rsp_long_level  = out_long_ff;
   assign rsp_short_level = out_short_ff;

endmodule

// ===== sv/twot_checker.sv =====
`timescale 1ns / 1ps
// port-level checker for the overcurrent trip core, bound to the top level
module twot_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [twot_pkg::STATE_BITS-1:0]       rsp_rail_state,
   input logic [twot_pkg::CAUSE_BITS-1:0]       rsp_trip_cause,
   input logic [twot_pkg::FAULT_BITS-1:0]       rsp_faults,
   input logic                                  rsp_refused,
   input logic [twot_pkg::LEVEL_BITS-1:0]       rsp_long_level,
   input logic [twot_pkg::LEVEL_BITS-1:0]       rsp_short_level
);
   import twot_pkg::*;

   // a held result keeps its valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   // a held result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_rail_state) && $stable(rsp_trip_cause)
         && $stable(rsp_faults) && $stable(rsp_refused)
         && $stable(rsp_long_level) && $stable(rsp_short_level))
      else $error("rsp payload changed while stalled");

   // a refusal only happens on a latched rail and never with a trip
   a_refused_latched: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_refused |->
         rsp_rail_state == STATE_LATCHED && rsp_trip_cause == CAUSE_NONE)
      else $error("refused item on a rail that is not latched");

   // a trip leaves the rail tripped or latched with at least one fault
   a_trip_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_trip_cause != CAUSE_NONE |->
         (rsp_rail_state == STATE_TRIPPED || rsp_rail_state == STATE_LATCHED)
         && rsp_faults != '0)
      else $error("trip reported without tripped state or fault count");

   // latching is only reached by a counted trip
   a_latched_faults: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rail_state == STATE_LATCHED |-> rsp_faults != '0)
      else $error("latched rail with empty fault counter");

endmodule

bind time_windowed_overcurrent_trip_core twot_checker u_twot_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_rail_state  (rsp_rail_state),
   .rsp_trip_cause  (rsp_trip_cause),
   .rsp_faults      (rsp_faults),
   .rsp_refused     (rsp_refused),
   .rsp_long_level  (rsp_long_level),
   .rsp_short_level (rsp_short_level)
);

// ===== test/time_windowed_overcurrent_trip_core_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the time-windowed overcurrent trip core
module time_windowed_overcurrent_trip_core_tb;
   import twot_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 7;
   localparam int MAX_WAIT     = 13;
   // margin after the last owed result is in
   localparam int DRAIN_CYCLES = 6;
   localparam int CYCLE_LIMIT  = 200000;
   // keeps the log short when the core is badly broken
   localparam int REPORT_LIMIT = 60;
   // indexes past the register list, writes there must be ignored
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_HI = 3'd7;

   // one result item as seen on the rsp channel
   typedef struct packed {
      logic [STATE_BITS-1:0] state;
      logic [CAUSE_BITS-1:0] cause;
      logic [FAULT_BITS-1:0] faults;
      logic                  refused;
      logic [LEVEL_BITS-1:0] long_lvl;
      logic [LEVEL_BITS-1:0] short_lvl;
   } rail_report_type;

   // rail model plus the queue of reports the core still owes it
   class trip_book_type;
      logic                       prot_on;
      logic [THRESH_BITS-1:0]     long_thr;
      logic [THRESH_BITS-1:0]     short_thr;
      logic [WINDOW_REG_BITS-1:0] long_win;
      logic [WINDOW_REG_BITS-1:0] short_win;
      logic [FAULT_BITS-1:0]      latch_at;
      logic [LEVEL_BITS-1:0]      long_acc;
      logic [LEVEL_BITS-1:0]      short_acc;
      logic [FAULT_BITS-1:0]      fault_cnt;
      logic [STATE_BITS-1:0]      rail;
      rail_report_type            due_reports[$];
      int                         errors;
      int                         reports;
      int                         trips;
      int                         refusals;
      bit                         full_seen;

      function new();
         prot_on   = PROTECT_ENABLE_RST;
         long_thr  = LONG_THRESHOLD_RST;
         short_thr = SHORT_THRESHOLD_RST;
         long_win  = LONG_WINDOW_RST;
         short_win = SHORT_WINDOW_RST;
         latch_at  = LATCH_AFTER_RST;
         long_acc  = '0;
         short_acc = '0;
         fault_cnt = '0;
         rail      = STATE_READY;
         errors    = 0;
         reports   = 0;
         trips     = 0;
         refusals  = 0;
         full_seen = 1'b0;
      endfunction

      function void write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
         case (idx)
            REG_PROTECT_ENABLE:  prot_on   = val[0];
            REG_LONG_THRESHOLD:  long_thr  = val[THRESH_BITS-1:0];
            REG_SHORT_THRESHOLD: short_thr = val[THRESH_BITS-1:0];
            REG_LONG_WINDOW:     long_win  = val[WINDOW_REG_BITS-1:0];
            REG_SHORT_WINDOW:    short_win = val[WINDOW_REG_BITS-1:0];
            REG_LATCH_AFTER:     latch_at  = val[FAULT_BITS-1:0];
            default: ;
         endcase
      endfunction

      // the window register is as wide as the accumulator, so the cap is the window
      function logic [LEVEL_BITS-1:0] bucket_next(logic [LEVEL_BITS-1:0] lvl,
                                                  logic [DT_BITS-1:0] dt, logic over,
                                                  logic [WINDOW_REG_BITS-1:0] win);
         logic [LEVEL_BITS:0] sum;
         sum = {1'b0, lvl} + (LEVEL_BITS+1)'(dt);
         if (over)
            return (sum > win) ? win : sum[LEVEL_BITS-1:0];
         return (lvl > dt) ? lvl - LEVEL_BITS'(dt) : '0;
      endfunction

      function void count_trip();
         if (fault_cnt != FAULT_MAX)
            fault_cnt++;
         rail = (fault_cnt < latch_at) ? STATE_TRIPPED : STATE_LATCHED;
         trips++;
      endfunction

      function void note_item(req_code_type kind, logic [CURRENT_BITS-1:0] cur,
                              logic [DT_BITS-1:0] dt_raw);
         logic [DT_BITS-1:0] dt;
         rail_report_type    r;
         r = '0;
         r.cause = CAUSE_NONE;
         dt = (dt_raw > DT_CAP_MS) ? DT_CAP_MS : dt_raw;
         case (kind)
            REQ_SAMPLE: if (prot_on) begin
               long_acc  = bucket_next(long_acc, dt, cur >= long_thr, long_win);
               short_acc = bucket_next(short_acc, dt, cur >= short_thr, short_win);
               if (short_acc >= short_win) begin
                  count_trip();
                  r.cause = CAUSE_SHORT;
               end else if (long_acc >= long_win) begin
                  count_trip();
                  r.cause = CAUSE_LONG;
               end
            end
            REQ_ENABLE: if (rail == STATE_LATCHED) begin
               r.refused = 1'b1;
               refusals++;
            end else begin
               rail      = STATE_RUNNING;
               long_acc  = '0;
               short_acc = '0;
            end
            REQ_DISABLE: if (rail == STATE_RUNNING)
               rail = STATE_READY;
            REQ_CLEAR: if (rail == STATE_LATCHED) begin
               fault_cnt = '0;
               long_acc  = '0;
               short_acc = '0;
               rail      = STATE_READY;
            end
            default: ;
         endcase
         r.state     = rail;
         r.faults    = fault_cnt;
         r.long_lvl  = long_acc;
         r.short_lvl = short_acc;
         due_reports.push_back(r);
      endfunction

      function void compare_field(string name, logic [LEVEL_BITS-1:0] want,
                                  logic [LEVEL_BITS-1:0] got);
         if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         end
      endfunction

      function void check_report(rail_report_type got);
         rail_report_type want;
         if (due_reports.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: result with no item outstanding, expected none, got %h",
                        $time, got);
            return;
         end
         want = due_reports.pop_front();
         reports++;
         if (want.faults == FAULT_MAX)
            full_seen = 1'b1;
         compare_field("rail_state", LEVEL_BITS'(want.state), LEVEL_BITS'(got.state));
         compare_field("trip_cause", LEVEL_BITS'(want.cause), LEVEL_BITS'(got.cause));
         compare_field("faults", LEVEL_BITS'(want.faults), LEVEL_BITS'(got.faults));
         compare_field("refused", LEVEL_BITS'(want.refused), LEVEL_BITS'(got.refused));
         compare_field("long_level", want.long_lvl, got.long_lvl);
         compare_field("short_level", want.short_lvl, got.short_lvl);
      endfunction
   endclass

   // every input starts at a known value
   logic                      clock          = 1'b0;
   logic                      reset          = 1'b1;
   logic                      csr_we         = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index      = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata      = '0;
   logic                      req_valid      = 1'b0;
   logic                      req_stall;
   logic [1:0]                req_type       = REQ_SAMPLE;
   logic [CURRENT_BITS-1:0]   req_current    = '0;
   logic [DT_BITS-1:0]        req_elapsed_ms = '0;
   logic                      rsp_valid;
   logic                      rsp_stall      = 1'b0;
   logic [STATE_BITS-1:0]     rsp_rail_state;
   logic [CAUSE_BITS-1:0]     rsp_trip_cause;
   logic [FAULT_BITS-1:0]     rsp_faults;
   logic                      rsp_refused;
   logic [LEVEL_BITS-1:0]     rsp_long_level;
   logic [LEVEL_BITS-1:0]     rsp_short_level;

   trip_book_type   book;
   bit              steady = 1'b0;     // when set, neither side idles
   int              stall_left = 0;
   int              items_sent = 0;
   int              cycles = 0;
   rail_report_type seen;

   time_windowed_overcurrent_trip_core u_top (.*);

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // hard stop in case the core hangs a handshake
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // idle cycles before an item, drawn afresh for every item on both sides
   function automatic int draw_wait();
      return steady ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // result side: take a result, then hold stall for a drawn number of cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.state     = rsp_rail_state;
            seen.cause     = rsp_trip_cause;
            seen.faults    = rsp_faults;
            seen.refused   = rsp_refused;
            seen.long_lvl  = rsp_long_level;
            seen.short_lvl = rsp_short_level;
            book.check_report(seen);
            stall_left = draw_wait();
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   // request side: valid is only lowered when a gap is actually wanted, so a
   // back-to-back item never sees valid dropped and raised in one step
   task automatic send_item(req_code_type kind, logic [CURRENT_BITS-1:0] cur,
                            logic [DT_BITS-1:0] dt);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_current    <= cur;
      req_elapsed_ms <= dt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      book.note_item(kind, cur, dt);
      items_sent++;
   endtask

   // quiet the request side and wait until every owed result is in
   task automatic settle();
      req_valid <= 1'b0;
      while (book.due_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      book.write_reg(idx, val);
   endtask

   task automatic load_settings(logic prot, logic [THRESH_BITS-1:0] lthr,
                                logic [THRESH_BITS-1:0] sthr,
                                logic [WINDOW_REG_BITS-1:0] lwin,
                                logic [WINDOW_REG_BITS-1:0] swin,
                                logic [FAULT_BITS-1:0] latch);
      set_reg(REG_PROTECT_ENABLE, CSR_DATA_BITS'(prot));
      set_reg(REG_LONG_THRESHOLD, CSR_DATA_BITS'(lthr));
      set_reg(REG_SHORT_THRESHOLD, CSR_DATA_BITS'(sthr));
      set_reg(REG_LONG_WINDOW, CSR_DATA_BITS'(lwin));
      set_reg(REG_SHORT_WINDOW, CSR_DATA_BITS'(swin));
      set_reg(REG_LATCH_AFTER, CSR_DATA_BITS'(latch));
   endtask

   // mostly samples with currents clustered on the thresholds, so the buckets
   // both fill and drain; commands keep the rail moving through its modes
   task automatic send_random(int sample_pct, bit allow_clear);
      req_code_type            kind;
      logic [CURRENT_BITS-1:0] cur;
      logic [DT_BITS-1:0]      dt;
      if ($urandom_range(0, 99) < sample_pct)
         kind = REQ_SAMPLE;
      else
         case ($urandom_range(0, allow_clear ? 2 : 1))
            0:       kind = REQ_ENABLE;
            1:       kind = REQ_DISABLE;
            default: kind = REQ_CLEAR;
         endcase
      case ($urandom_range(0, 7))
         0:       cur = '0;
         1:       cur = '1;
         2:       cur = book.long_thr;
         3:       cur = book.short_thr;
         4:       cur = book.long_thr - 1'b1;
         5:       cur = book.short_thr - 1'b1;
         default: cur = CURRENT_BITS'($urandom);
      endcase
      case ($urandom_range(0, 9))
         0:       dt = '0;
         1:       dt = DT_CAP_MS;
         2:       dt = DT_CAP_MS + 1'b1;
         3:       dt = '1;
         4:       dt = DT_BITS'($urandom);
         default: dt = DT_BITS'($urandom_range(0, DT_CAP_MS));
      endcase
      send_item(kind, cur, dt);
   endtask

   task automatic run_random(int count, int sample_pct, bit allow_clear);
      for (int i = 0; i < count; i++) begin
         // now and then a stretch where neither side idles
         if (i % 40 == 0)
            steady = ($urandom_range(0, 3) == 0);
         send_random(sample_pct, allow_clear);
      end
      steady = 1'b0;
   endtask

   initial begin
      book = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed part on reset settings: sample while ready, then bucket edges
      send_item(REQ_SAMPLE, 16'd0, 16'd0);
      send_item(REQ_ENABLE, 16'd0, 16'd0);
      send_item(REQ_SAMPLE, 16'hFFFF, 16'hFFFF);      // elapsed clipped to the cap
      send_item(REQ_SAMPLE, 16'd10000, 16'd1000);     // exactly on the short threshold
      send_item(REQ_SAMPLE, 16'd9999, 16'd500);       // only the long bucket fills
      send_item(REQ_SAMPLE, 16'd7999, 16'd1001);      // both drain
      send_item(REQ_DISABLE, 16'd0, 16'd0);
      send_item(REQ_DISABLE, 16'd0, 16'd0);           // already ready
      send_item(REQ_CLEAR, 16'd0, 16'd0);             // not latched, ignored
      send_item(REQ_SAMPLE, 16'd0, 16'hFFFF);         // floors at zero
      settle();

      // short windows: short trip, then long trip that latches
      set_reg(REG_LONG_WINDOW, 24'd3000);
      set_reg(REG_SHORT_WINDOW, 24'd2000);
      set_reg(REG_LATCH_AFTER, 24'd2);
      send_item(REQ_ENABLE, 16'd0, 16'd0);
      send_item(REQ_SAMPLE, 16'hFFFF, 16'd1000);
      send_item(REQ_SAMPLE, 16'hFFFF, 16'd1000);
      send_item(REQ_SAMPLE, 16'd8000, 16'd1000);
      send_item(REQ_ENABLE, 16'd0, 16'd0);            // refused while latched
      send_item(REQ_DISABLE, 16'd0, 16'd0);           // latched stays latched
      send_item(REQ_CLEAR, 16'd0, 16'd0);
      send_item(REQ_SAMPLE, 16'hAAAA, 16'h5555);
      send_item(REQ_SAMPLE, 16'h5555, 16'hAAAA);
      settle();

      // protection off, and writes to unmapped indexes
      set_reg(REG_PROTECT_ENABLE, 24'd0);
      set_reg(REG_SPARE_LO, 24'hFFFFFF);
      set_reg(REG_SPARE_HI, 24'h000001);
      send_item(REQ_SAMPLE, 16'hFFFF, 16'd1000);
      settle();

      // zero short window trips on every sample, zero latch count latches at once
      set_reg(REG_PROTECT_ENABLE, 24'd1);
      set_reg(REG_SHORT_WINDOW, 24'd0);
      set_reg(REG_LATCH_AFTER, 24'd0);
      send_item(REQ_SAMPLE, 16'd0, 16'd0);
      send_item(REQ_CLEAR, 16'd0, 16'd0);
      settle();

      // random part: small windows so trips come often
      for (int phase = 0; phase < 2; phase++) begin
         load_settings(1'b1, THRESH_BITS'($urandom), THRESH_BITS'($urandom),
                       WINDOW_REG_BITS'($urandom_range(1000, 6000)),
                       WINDOW_REG_BITS'($urandom_range(300, 3000)),
                       FAULT_BITS'($urandom_range(1, 6)));
         run_random(35, 78, 1'b1);
         settle();
      end

      // widest windows and lowest thresholds: buckets only climb
      load_settings(1'b1, 16'd0, 16'd0, 24'hFFFFFF, 24'hFFFFFF, 8'd255);
      run_random(30, 78, 1'b1);
      settle();

      // highest thresholds and one-millisecond windows
      load_settings(1'b1, 16'hFFFF, 16'hFFFF, 24'd1, 24'd1, 8'd1);
      run_random(30, 78, 1'b1);
      settle();

      // protection off with random content
      set_reg(REG_PROTECT_ENABLE, 24'd0);
      run_random(20, 78, 1'b1);
      settle();

      // every sample trips and nothing clears, so the fault counter runs into its ceiling
      load_settings(1'b1, THRESH_BITS'($urandom), THRESH_BITS'($urandom),
                    24'hFFFFFF, 24'd0, 8'd0);
      run_random(280, 96, 1'b0);
      settle();

      $display("covered %0d items: %0d results checked, %0d trips, %0d refused enables",
               items_sent, book.reports, book.trips, book.refusals);
      $display("fault counter %s its ceiling, %0d mismatches",
               book.full_seen ? "reached" : "did not reach", book.errors);
      if (book.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
